// ===== rtl/core/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and constants for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned VLQ_W      = 28;
    localparam int unsigned VLQ_CNT_W  = 3;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [7:0] STATUS_NONE    = 8'h00;
    localparam logic [7:0] STATUS_SYS     = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_E = 8'hF7;
    localparam logic [7:0] STATUS_META    = 8'hFF;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;

    localparam logic [VLQ_CNT_W-1:0] VLQ_MAX_BYTES = VLQ_CNT_W'(4);

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_META_TYPE,
        PH_META_LEN,
        PH_SYSEX_LEN,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHANNEL,
        KIND_META,
        KIND_SYSEX,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        phase_t                phase;
        logic [VLQ_W-1:0]      vlq_value;
        logic [VLQ_CNT_W-1:0]  vlq_bytes;
        logic [TICK_W-1:0]     tick_total;
        logic [7:0]            running_status;
        logic [7:0]            current_status;
        logic [7:0]            first_data;
        logic [7:0]            meta_type;
        logic [VLQ_W-1:0]      skip_left;
    } parse_state_t;

    typedef struct packed {
        logic [TICK_W-1:0] event_tick;
        logic [7:0]        event_status;
        logic [7:0]        event_data1;
        logic [7:0]        event_data2;
        kind_t             event_kind;
        logic [7:0]        meta_kind;
        logic              track_end;
    } event_t;

endpackage

// ===== rtl/core/mtep_step.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser step
// Next parser state and optional event for one track byte.
// ----------------------------------------------------------------------------
module mtep_step (
    input  logic [7:0]             in_byte,
    input  mtep_pkg::parse_state_t state,
    output mtep_pkg::parse_state_t state_next,
    output logic                   emit,
    output mtep_pkg::event_t       evt
);
    import mtep_pkg::*;

    logic [VLQ_W-1:0]     vlq_val_new;
    logic [VLQ_CNT_W-1:0] vlq_bytes_new;
    logic                 vlq_done;
    logic [VLQ_W-1:0]     skip_dec;
    logic                 chan_go;
    logic [7:0]           chan_st;
    logic                 long_done;
    logic                 is_end;

    assign vlq_val_new   = {state.vlq_value[VLQ_W-8:0], in_byte[6:0]};
    assign vlq_bytes_new = state.vlq_bytes + VLQ_CNT_W'(1);
    assign vlq_done      = !in_byte[7] || (vlq_bytes_new >= VLQ_MAX_BYTES);
    assign skip_dec      = state.skip_left - VLQ_W'(1);
    assign is_end        = (state.meta_type == META_END_TRACK);

    always_comb begin
        state_next = state;
        emit       = 1'b0;
        chan_go    = 1'b0;
        chan_st    = state.current_status;
        long_done  = 1'b0;
        evt.event_tick   = state.tick_total;
        evt.event_status = STATUS_NONE;
        evt.event_data1  = 8'h00;
        evt.event_data2  = 8'h00;
        evt.event_kind   = KIND_CHANNEL;
        evt.meta_kind    = 8'h00;
        evt.track_end    = 1'b0;

        unique case (state.phase)
            PH_DELTA: begin
                state_next.vlq_value = vlq_val_new;
                state_next.vlq_bytes = vlq_bytes_new;
                if (vlq_done) begin
                    state_next.tick_total = state.tick_total + TICK_W'(vlq_val_new);
                    state_next.vlq_value  = '0;
                    state_next.vlq_bytes  = '0;
                    state_next.phase      = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (!in_byte[7]) begin
                    if (state.running_status == STATUS_NONE) begin
                        state_next.current_status = STATUS_NONE;
                        state_next.phase          = PH_DELTA;
                        emit             = 1'b1;
                        evt.event_data1  = in_byte;
                        evt.event_kind   = KIND_ERROR;
                    end else begin
                        state_next.current_status = state.running_status;
                        chan_go = 1'b1;
                        chan_st = state.running_status;
                    end
                end else if (in_byte < STATUS_SYS) begin
                    state_next.current_status = in_byte;
                    state_next.running_status = in_byte;
                    state_next.phase          = PH_DATA1;
                end else begin
                    state_next.running_status = STATUS_NONE;
                    state_next.vlq_value      = '0;
                    state_next.vlq_bytes      = '0;
                    if (in_byte == STATUS_META) begin
                        state_next.current_status = in_byte;
                        state_next.phase          = PH_META_TYPE;
                    end else if (in_byte == STATUS_SYSEX || in_byte == STATUS_SYSEX_E) begin
                        state_next.current_status = in_byte;
                        state_next.phase          = PH_SYSEX_LEN;
                    end else begin
                        state_next.current_status = STATUS_NONE;
                        state_next.phase          = PH_DELTA;
                        emit             = 1'b1;
                        evt.event_status = in_byte;
                        evt.event_kind   = KIND_ERROR;
                    end
                end
            end
            PH_DATA1: begin
                chan_go = 1'b1;
            end
            PH_DATA2: begin
                state_next.phase = PH_DELTA;
                emit             = 1'b1;
                evt.event_status = state.current_status;
                evt.event_data1  = state.first_data;
                evt.event_data2  = in_byte;
            end
            PH_META_TYPE: begin
                state_next.meta_type = in_byte;
                state_next.vlq_value = '0;
                state_next.vlq_bytes = '0;
                state_next.phase     = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                state_next.vlq_value = vlq_val_new;
                state_next.vlq_bytes = vlq_bytes_new;
                if (vlq_done) begin
                    state_next.skip_left = vlq_val_new;
                    state_next.vlq_value = '0;
                    state_next.vlq_bytes = '0;
                    if (vlq_val_new == '0) begin
                        long_done = 1'b1;
                    end else begin
                        state_next.phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                state_next.skip_left = skip_dec;
                if (skip_dec == '0) begin
                    long_done = 1'b1;
                end
            end
        endcase

        if (chan_go) begin
            if (chan_st[7:4] != HI_PROG_CHANGE && chan_st[7:4] != HI_CHAN_PRESS) begin
                state_next.first_data = in_byte;
                state_next.phase      = PH_DATA2;
            end else begin
                state_next.phase = PH_DELTA;
                emit             = 1'b1;
                evt.event_status = chan_st;
                evt.event_data1  = in_byte;
            end
        end

        if (long_done) begin
            state_next.phase = PH_DELTA;
            emit             = 1'b1;
            if (state.current_status == STATUS_META) begin
                evt.event_status = STATUS_META;
                evt.event_kind   = KIND_META;
                evt.meta_kind    = state.meta_type;
                evt.track_end    = is_end;
                if (is_end) begin
                    state_next.tick_total     = '0;
                    state_next.running_status = STATUS_NONE;
                    state_next.current_status = STATUS_NONE;
                end
            end else begin
                evt.event_status = state.current_status;
                evt.event_kind   = KIND_SYSEX;
            end
        end
    end

endmodule

// ===== rtl/core/mtep_out_reg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser output register
// Holds one finished event until the downstream side takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  mtep_pkg::event_t                     evt,
    output logic                                 space,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mtep_pkg::OUT_DATA_W-1:0]      m_tdata,  // tick, status, data1, data2, kind, meta_kind
    output logic                                 m_tlast   // track_end
);
    import mtep_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t evt_reg;

    assign space      = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            evt_reg <= evt;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = evt_reg.track_end;
    assign m_tdata  = {6'b0, evt_reg.meta_kind, evt_reg.event_kind, evt_reg.event_data2,
                       evt_reg.event_data1, evt_reg.event_status, evt_reg.event_tick};

endmodule

// ===== rtl/core/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses standard MIDI file track event bytes into timed events.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one track byte per item on s_tdata.
//   m_ channel: one item per completed event; m_tdata carries absolute tick,
//   status, two data bytes, event kind and meta type; m_tlast marks the
//   end-of-track event, after which tick total and running status restart.
//   Pipeline: an accepted byte waits in the input register, is parsed into the output
//   register when the parse can proceed, and its event is then shown on m_tvalid.
//   Throughput: one byte per cycle when not stalled; the parse step is a single
//   pass of shift-or, add and compare logic between the input and output registers.
//   Bytes that complete no event produce no item.
//   Stall: while m_tready is low one event waits in the output register and
//   the next event-completing byte waits in the input register; s_tready drops.
//   Reset: aresetn low for one edge empties both registers and returns the
//   parser to expecting a delta time with tick zero and no running status.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mtep_pkg::IN_DATA_W-1:0]       s_tdata,  // in_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mtep_pkg::OUT_DATA_W-1:0]      m_tdata,  // event_tick, event_status,
                                                           // event_data1, event_data2,
                                                           // event_kind, meta_kind
    output logic                                 m_tlast   // track_end
);
    import mtep_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [IN_DATA_W-1:0] in_byte_reg;
    parse_state_t         state_reg;
    parse_state_t         state_next;
    logic                 emit;
    event_t               evt;
    logic                 out_space;
    logic                 proc_fire;
    logic                 s_fire;

    assign proc_fire     = in_valid_reg && (!emit || out_space);
    assign s_tready      = !in_valid_reg || proc_fire;
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !proc_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_DELTA, default: '0};
        end else if (proc_fire) begin
            state_reg <= state_next;
        end
    end

    mtep_step u_step (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (emit),
        .evt        (evt)
    );

    mtep_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_fire && emit),
        .evt      (evt),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_end_is_meta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[57:56] == KIND_META && m_tdata[39:32] == STATUS_META)
        else $error("track end on a non-meta event");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && emit && evt.track_end |=> state_reg.tick_total == '0 &&
            state_reg.running_status == STATUS_NONE)
        else $error("tick total or running status kept after track end");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[57:56] == KIND_ERROR |-> m_tdata[55:48] == 8'h00 &&
            m_tdata[65:58] == 8'h00 && !m_tlast)
        else $error("error event carries data2 or meta type");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("waiting event overwritten");
`endif

endmodule
